>>> src/ste_pkg.sv
package ste_pkg;

  // fixed widths of the day count, of the configuration registers and of the bus port
  localparam int DAY_W  = 31;
  localparam int REG_W  = 9;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // signed width for day arithmetic on register values (ramps may overrun the year)
  localparam int SW = REG_W + 3;

  localparam logic [REG_W-1:0] REG_RESET = REG_W'(2);

  typedef enum logic [1:0] {
    REG_RAMP_UP    = 2'd0,
    REG_RAMP_DOWN  = 2'd1,
    REG_CUTOFF     = 2'd2,
    REG_PEAK_START = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_ZERO = 2'd0,
    PH_UP   = 2'd1,
    PH_PEAK = 2'd2,
    PH_DOWN = 2'd3
  } phase_t;

  // comparisons of the day of year against the derived season points
  typedef struct packed {
    logic rise_in_year;   // rise starts after day 0
    logic n_ge_psu;
    logic n_lt_ps;
    logic n_le_pe;
    logic n_le_perd;
    logic n_lt_perdd;
    logic n_ge_psud;
    logic ps_ge_pe;
    logic ps_gt_pe;
    logic perd_lt_d;
  } cmp_t;

endpackage

>>> src/seasonal_trapezoid_envelope.sv
// Yearly trapezoid envelope.
// Input: pulse start with a day count on in_sim_day; busy is always low, so a
// word can be started on every clock cycle.
// Output: out_valid is high for one cycle with out_amplitude (unsigned,
// FRACTION_BITS fraction bits, full scale is 1.0) and out_phase
// (zero, ramping up, plateau, ramping down). The receiver cannot stall the
// block and needs no flow control: every word is delivered exactly once.
// Throughput is one word per cycle.
// The pipeline is six stages of day reduction and season decoding (reciprocal
// multiply, correction, compares, numerator select) followed by one stage per
// fraction bit of a restoring divider for the ramp slopes.
// Configuration goes through the APB-style port: rise length at 0x0,
// fall length at 0x4, dead days per year at 0x8 and peak_start at 0xC, 9 bits
// each. Write only while no word is in flight. Derived season points are
// registered in turn behind the configuration registers.
// Reset clears the pipeline valid bits and sets every configuration register to 2.
module seasonal_trapezoid_envelope #(
  parameter int DAYS_PER_YEAR = 365,
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ste_pkg::DAY_W-1:0]     in_sim_day,
  output logic                          out_valid,
  output logic [FRACTION_BITS:0]        out_amplitude,
  output logic [1:0]                    out_phase,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ste_pkg::ADDR_W-1:0]    paddr,
  input  logic [ste_pkg::DATA_W-1:0]    pwdata,
  output logic [ste_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  localparam int DW    = ste_pkg::DAY_W;
  localparam int CW    = ste_pkg::REG_W;
  localparam int SW    = ste_pkg::SW;
  localparam int XW    = ste_pkg::DATA_W;
  localparam int NB    = $clog2(DAYS_PER_YEAR);
  localparam int RMW   = NB + 1;
  localparam int RSH   = DW + NB;
  localparam int RCP_W = DW + 1;
  localparam int PW    = DW + RCP_W;
  localparam int FB    = FRACTION_BITS;
  localparam int AW    = FB + 1;

  localparam logic [RCP_W-1:0]     RCP = RCP_W'((64'd1 << RSH) / DAYS_PER_YEAR);
  localparam logic signed [SW-1:0] DS  = SW'(DAYS_PER_YEAR);
  localparam logic [RMW-1:0]       DR  = RMW'(DAYS_PER_YEAR);
  localparam logic [AW-1:0]        AMP_ONE = {1'b1, {FB{1'b0}}};

  function automatic logic signed [SW-1:0] ext_cfg(input logic [CW-1:0] v);
    return $signed({{(SW-CW){1'b0}}, v});
  endfunction

  // configuration registers
  logic [CW-1:0] ramp_up_r, fall_len_r, cutoff_r, peak_start_r;
  logic          wr_en;

  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_up_r    <= ste_pkg::REG_RESET;
      fall_len_r   <= ste_pkg::REG_RESET;
      cutoff_r     <= ste_pkg::REG_RESET;
      peak_start_r <= ste_pkg::REG_RESET;
    end else if (wr_en) begin
      case (ste_pkg::cfg_reg_t'(paddr[3:2]))
        ste_pkg::REG_RAMP_UP:    ramp_up_r    <= pwdata[CW-1:0];
        ste_pkg::REG_RAMP_DOWN:  fall_len_r   <= pwdata[CW-1:0];
        ste_pkg::REG_CUTOFF:     cutoff_r     <= pwdata[CW-1:0];
        ste_pkg::REG_PEAK_START: peak_start_r <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ste_pkg::cfg_reg_t'(paddr[3:2]))
      ste_pkg::REG_RAMP_UP:    prdata = XW'(ramp_up_r);
      ste_pkg::REG_RAMP_DOWN:  prdata = XW'(fall_len_r);
      ste_pkg::REG_CUTOFF:     prdata = XW'(cutoff_r);
      ste_pkg::REG_PEAK_START: prdata = XW'(peak_start_r);
      default:                 prdata = '0;
    endcase
  end

  // derived season points, three register levels behind the configuration
  logic signed [SW-1:0] ps_a_r, sum_a_r, psru_a_r;
  logic signed [SW-1:0] ps_r, psu_r, psud_r, pe_raw_r, perd_raw_r;
  logic signed [SW-1:0] pe_r, perd_r, perdd_r, ps_c_r;
  logic signed [SW-1:0] ps_a_nxt;

  always_comb begin
    ps_a_nxt = ext_cfg(peak_start_r);
    if (ps_a_nxt > DS) ps_a_nxt = ps_a_nxt - DS;
  end

  always_ff @(posedge clk) begin
    ps_a_r   <= ps_a_nxt;
    sum_a_r  <= ext_cfg(ramp_up_r) + ext_cfg(fall_len_r) + ext_cfg(cutoff_r);
    psru_a_r <= ext_cfg(ramp_up_r) + ext_cfg(cutoff_r);

    ps_r       <= ps_a_r;
    psu_r      <= ps_a_r - ext_cfg(ramp_up_r);
    psud_r     <= ps_a_r - ext_cfg(ramp_up_r) + DS;
    pe_raw_r   <= ps_a_r + DS - sum_a_r;
    perd_raw_r <= ps_a_r + DS - psru_a_r;

    ps_c_r <= ps_r;
    if (pe_raw_r > DS) begin
      pe_r    <= pe_raw_r - DS;
      perd_r  <= perd_raw_r - DS;
      perdd_r <= perd_raw_r - DS - DS;
    end else begin
      pe_r    <= pe_raw_r;
      perd_r  <= perd_raw_r;
      perdd_r <= perd_raw_r - DS;
    end
  end

  // S1: capture
  logic          v1_r;
  logic [DW-1:0] x1_r;
  // S2: quotient by reciprocal multiply
  logic          v2_r;
  logic [DW-1:0] x2_r;
  logic [RMW-1:0] q2_r;
  logic [PW-1:0] prod;
  // S3: raw remainder, below twice the year
  logic           v3_r;
  logic [RMW-1:0] r3_r;
  // S4: day of year
  logic          v4_r;
  logic [NB-1:0] n4_r;
  // S5: compares
  logic          v5_r;
  logic [NB-1:0] n5_r;
  ste_pkg::cmp_t c5_r, c5_nxt;
  logic signed [SW-1:0] sn4, sn5;
  // S6: phase and divider operands
  logic            v6_r;
  logic [CW-1:0]   num6_r, dv6_r;
  logic            top6_r;
  ste_pkg::phase_t ph6_r, ph6_nxt;
  logic signed [SW-1:0] base6, diff6;

  assign prod = {{RCP_W{1'b0}}, x1_r} * {{DW{1'b0}}, RCP};
  assign sn4  = $signed({{(SW-NB){1'b0}}, n4_r});
  assign sn5  = $signed({{(SW-NB){1'b0}}, n5_r});

  always_comb begin
    c5_nxt.rise_in_year = psu_r > 0;
    c5_nxt.n_ge_psu     = sn4 >= psu_r;
    c5_nxt.n_lt_ps      = sn4 < ps_c_r;
    c5_nxt.n_le_pe      = sn4 <= pe_r;
    c5_nxt.n_le_perd    = sn4 <= perd_r;
    c5_nxt.n_lt_perdd   = sn4 < perdd_r;
    c5_nxt.n_ge_psud    = sn4 >= psud_r;
    c5_nxt.ps_ge_pe     = ps_c_r >= pe_r;
    c5_nxt.ps_gt_pe     = ps_c_r > pe_r;
    c5_nxt.perd_lt_d    = perd_r < DS;
  end

  // season decode, in the priority order of the two rise cases
  always_comb begin
    ph6_nxt = ste_pkg::PH_ZERO;
    base6   = psu_r;
    if (c5_r.rise_in_year) begin
      if (c5_r.n_ge_psu && c5_r.n_lt_ps) begin
        ph6_nxt = ste_pkg::PH_UP;
      end else if (c5_r.ps_ge_pe && (!c5_r.n_lt_ps || c5_r.n_le_pe)) begin
        ph6_nxt = ste_pkg::PH_PEAK;
      end else if (!c5_r.ps_ge_pe && !c5_r.n_lt_ps && c5_r.n_le_pe) begin
        ph6_nxt = ste_pkg::PH_PEAK;
      end else if (c5_r.perd_lt_d && !c5_r.n_le_pe && c5_r.n_le_perd) begin
        ph6_nxt = ste_pkg::PH_DOWN;
        base6   = perd_r;
      end else if (!c5_r.perd_lt_d && (!c5_r.n_le_pe || c5_r.n_lt_perdd)) begin
        ph6_nxt = ste_pkg::PH_DOWN;
        // the part after the year start wins
        base6   = c5_r.n_lt_perdd ? perdd_r : perd_r;
      end
    end else begin
      if (c5_r.n_ge_psud) begin
        ph6_nxt = ste_pkg::PH_UP;
        base6   = psud_r;
      end else if (c5_r.n_lt_ps) begin
        ph6_nxt = ste_pkg::PH_UP;
      end
      if (c5_r.ps_gt_pe && (!c5_r.n_lt_ps || c5_r.n_le_pe)) begin
        ph6_nxt = ste_pkg::PH_PEAK;
      end else if (!c5_r.ps_ge_pe && !c5_r.n_lt_ps && c5_r.n_le_pe) begin
        ph6_nxt = ste_pkg::PH_PEAK;
      end else if (!c5_r.n_le_pe && c5_r.n_le_perd) begin
        ph6_nxt = ste_pkg::PH_DOWN;
        base6   = perd_r;
      end
    end
    // rise counts days from its start, fall counts days left to its end
    if (ph6_nxt == ste_pkg::PH_UP) diff6 = sn5 - base6;
    else                           diff6 = base6 - sn5;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    x1_r <= in_sim_day;
    x2_r <= x1_r;
    q2_r <= prod[RSH+RMW-1:RSH];
    r3_r <= x2_r[RMW-1:0] - RMW'(q2_r * DR);
    n4_r <= (r3_r >= DR) ? NB'(r3_r - DR) : NB'(r3_r);
    n5_r <= n4_r;
    c5_r <= c5_nxt;
    ph6_r  <= ph6_nxt;
    num6_r <= diff6[CW-1:0];
    dv6_r  <= (ph6_nxt == ste_pkg::PH_UP) ? ramp_up_r : fall_len_r;
    // a fall whose wrapped part starts right at the year start is at full level
    top6_r <= (ph6_nxt == ste_pkg::PH_DOWN) && (diff6 == ext_cfg(fall_len_r));
  end

  // restoring divider, one quotient bit per stage; numerator is below divisor
  logic            dvld_r [FB];
  logic [CW-1:0]   drem_r [FB];
  logic [CW-1:0]   ddv_r  [FB];
  logic [FB-1:0]   dq_r   [FB];
  logic            dtop_r [FB];
  ste_pkg::phase_t dph_r  [FB];

  for (genvar g = 0; g < FB; g++) begin : g_div
    logic            vld_in;
    logic [CW-1:0]   rem_in, dv_in;
    logic [FB-1:0]   q_in;
    logic            top_in;
    ste_pkg::phase_t ph_in;
    logic [CW:0]     r2, diff;
    logic            take;

    if (g == 0) begin : g_first
      assign vld_in = v6_r;
      assign rem_in = num6_r;
      assign dv_in  = dv6_r;
      assign q_in   = '0;
      assign top_in = top6_r;
      assign ph_in  = ph6_r;
    end else begin : g_next
      assign vld_in = dvld_r[g-1];
      assign rem_in = drem_r[g-1];
      assign dv_in  = ddv_r[g-1];
      assign q_in   = dq_r[g-1];
      assign top_in = dtop_r[g-1];
      assign ph_in  = dph_r[g-1];
    end

    assign r2   = {rem_in, 1'b0};
    assign take = r2 >= {1'b0, dv_in};
    assign diff = r2 - {1'b0, dv_in};

    always_ff @(posedge clk) begin
      if (!rst_n) dvld_r[g] <= 1'b0;
      else        dvld_r[g] <= vld_in;
    end

    always_ff @(posedge clk) begin
      drem_r[g] <= take ? diff[CW-1:0] : r2[CW-1:0];
      ddv_r[g]  <= dv_in;
      dq_r[g]   <= {q_in[FB-2:0], take};
      dtop_r[g] <= top_in;
      dph_r[g]  <= ph_in;
    end
  end

  // output word
  logic            out_valid_r;
  logic [AW-1:0]   out_amplitude_r, amp_nxt;
  ste_pkg::phase_t out_phase_r;

  always_comb begin
    case (dph_r[FB-1])
      ste_pkg::PH_PEAK: amp_nxt = AMP_ONE;
      ste_pkg::PH_UP,
      ste_pkg::PH_DOWN: amp_nxt = dtop_r[FB-1] ? AMP_ONE : {1'b0, dq_r[FB-1]};
      default:          amp_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= dvld_r[FB-1];
  end

  always_ff @(posedge clk) begin
    out_amplitude_r <= amp_nxt;
    out_phase_r     <= dph_r[FB-1];
  end

  assign out_valid     = out_valid_r;
  assign out_amplitude = out_amplitude_r;
  assign out_phase     = out_phase_r;

endmodule
